FILE: design/atids_pkg.sv
// Shared types, codes and defaults for the array table insert/delete/search block.
package atids_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam logic [2:0] REQ_CLEAR   = 3'd0;
    localparam logic [2:0] REQ_APPEND  = 3'd1;
    localparam logic [2:0] REQ_DISPLAY = 3'd2;
    localparam logic [2:0] REQ_INSERT  = 3'd3;
    localparam logic [2:0] REQ_DELETE  = 3'd4;
    localparam logic [2:0] REQ_SEARCH  = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_BAD_POS   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    localparam logic [2:0] IDX_HOLD     = 3'd0;
    localparam logic [2:0] IDX_ZERO     = 3'd1;
    localparam logic [2:0] IDX_COUNT    = 3'd2;
    localparam logic [2:0] IDX_POS_M1   = 3'd3;
    localparam logic [2:0] IDX_INC      = 3'd4;
    localparam logic [2:0] IDX_DEC      = 3'd5;

    localparam logic [1:0] RD_AT_IDX    = 2'd0;
    localparam logic [1:0] RD_AT_IDX_M1 = 2'd1;
    localparam logic [1:0] RD_AT_IDX_P1 = 2'd2;

    localparam logic [1:0] CNT_HOLD     = 2'd0;
    localparam logic [1:0] CNT_CLEAR    = 2'd1;
    localparam logic [1:0] CNT_INC      = 2'd2;
    localparam logic [1:0] CNT_DEC      = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
        logic [6:0]         position;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [6:0]         position_out;
        logic [2:0]         status;
        logic               last;
    } res_t;

    typedef struct packed {
        logic       load_req;
        logic [2:0] idx_op;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_en;
        logic       wr_at_count;
        logic       wr_from_rdata;
        logic [1:0] cnt_op;
        logic       emit;
        logic [2:0] emit_status;
        logic       emit_data;
        logic       emit_pos;
        logic       emit_last;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       full;
        logic       empty;
        logic       ins_ok;
        logic       del_ok;
        logic       ins_done;
        logic       at_last;
        logic       match;
    } stat_t;

endpackage

FILE: design/atids_dpath.sv
// Datapath: element memory, fill count, walk index, request latch and result register.
module atids_dpath #(
    parameter int DEPTH = atids_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  atids_pkg::req_t  req,
    input  atids_pkg::cmd_t  cmd,
    output atids_pkg::stat_t stat,
    output atids_pkg::res_t  res,
    output logic             res_valid
);
    import atids_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   element_mem [DEPTH];
    req_t          req_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [31:0]   rdata_reg;
    res_t          res_reg;
    res_t          res_next;
    logic          res_valid_reg;

    logic [CW-1:0] idx_inc;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    assign idx_inc = CW'(idx_reg) + CW'(1);

    always_comb
    begin
        stat.req_type = req_reg.req_type;
        stat.full     = (count_reg == CW'(DEPTH));
        stat.empty    = (count_reg == '0);
        stat.ins_ok   = (req_reg.position != 7'd0)
                        && ({1'b0, req_reg.position} <= (8'(count_reg) + 8'd1));
        stat.del_ok   = (req_reg.position != 7'd0)
                        && ({1'b0, req_reg.position} <= 8'(count_reg));
        stat.ins_done = (7'(idx_reg) == (req_reg.position - 7'd1));
        stat.at_last  = (idx_inc == count_reg);
        stat.match    = (rdata_reg == req_reg.value);
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_AT_IDX_M1: rd_addr = idx_reg - AW'(1);
            RD_AT_IDX_P1: rd_addr = idx_reg + AW'(1);
            default:      rd_addr = idx_reg;
        endcase
        wr_addr = cmd.wr_at_count ? AW'(count_reg) : idx_reg;
        wr_data = cmd.wr_from_rdata ? rdata_reg : req_reg.value;
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_ZERO:   idx_next = '0;
            IDX_COUNT:  idx_next = AW'(count_reg);
            IDX_POS_M1: idx_next = AW'(req_reg.position - 7'd1);
            IDX_INC:    idx_next = idx_reg + AW'(1);
            IDX_DEC:    idx_next = idx_reg - AW'(1);
            default:    idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_CLEAR: count_next = '0;
            CNT_INC:   count_next = count_reg + CW'(1);
            CNT_DEC:   count_next = count_reg - CW'(1);
            default:   count_next = count_reg;
        endcase
    end

    always_comb
    begin
        res_next.value_out    = cmd.emit_data ? rdata_reg : 32'd0;
        res_next.position_out = cmd.emit_pos ? 7'(idx_inc) : 7'd0;
        res_next.status       = cmd.emit_status;
        res_next.last         = cmd.emit_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        idx_reg <= idx_next;
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            element_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= element_mem[rd_addr];
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

FILE: design/atids_ctrl.sv
// Controller: state machine that sequences each request over the datapath.
module atids_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  atids_pkg::stat_t stat,
    output atids_pkg::cmd_t  cmd,
    output logic             busy
);
    import atids_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_INS_STEP = 4'd2;
    localparam logic [3:0] S_INS_WR   = 4'd3;
    localparam logic [3:0] S_DEL_STEP = 4'd4;
    localparam logic [3:0] S_DEL_WR   = 4'd5;
    localparam logic [3:0] S_DISP_RD  = 4'd6;
    localparam logic [3:0] S_DISP_OUT = 4'd7;
    localparam logic [3:0] S_SRCH_RD  = 4'd8;
    localparam logic [3:0] S_SRCH_CMP = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.req_type)
                    REQ_CLEAR:
                    begin
                        cmd.cnt_op    = CNT_CLEAR;
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                    end
                    REQ_APPEND:
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        if (stat.full)
                        begin
                            cmd.emit_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en       = 1'b1;
                            cmd.wr_at_count = 1'b1;
                            cmd.cnt_op      = CNT_INC;
                        end
                    end
                    REQ_DISPLAY:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_DISP_RD;
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_FULL;
                        end
                        else if (!stat.ins_ok)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_BAD_POS;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_COUNT;
                            state_next = S_INS_STEP;
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_EMPTY;
                        end
                        else if (!stat.del_ok)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_BAD_POS;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_POS_M1;
                            state_next = S_DEL_STEP;
                        end
                    end
                    REQ_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_SRCH_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS_STEP:
            begin
                if (stat.ins_done)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.cnt_op    = CNT_INC;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_AT_IDX_M1;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_en         = 1'b1;
                cmd.wr_from_rdata = 1'b1;
                cmd.idx_op        = IDX_DEC;
                state_next        = S_INS_STEP;
            end
            S_DEL_STEP:
            begin
                if (stat.at_last)
                begin
                    cmd.cnt_op    = CNT_DEC;
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_AT_IDX_P1;
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                cmd.wr_en         = 1'b1;
                cmd.wr_from_rdata = 1'b1;
                cmd.idx_op        = IDX_INC;
                state_next        = S_DEL_STEP;
            end
            S_DISP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT_IDX;
                state_next = S_DISP_OUT;
            end
            S_DISP_OUT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_data = 1'b1;
                cmd.emit_pos  = 1'b1;
                cmd.emit_last = stat.at_last;
                if (stat.at_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_DISP_RD;
                end
            end
            S_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT_IDX;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_pos  = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (stat.at_last)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_SRCH_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: design/array_table_insert_delete_search_top.sv
// Top level of the array table block: ordered list with clear, append, display, insert, delete and search.
//
//   Channel   Handshake            Payload
//   request   start / busy         req (req_type, value, position)
//   result    res_valid strobe     res (value_out, position_out, status, last)
//
// A request transfers on a clock edge with start high and busy low; a decode state
// follows before any result. Display, search, insert and delete walk the element
// memory one element at a time: the memory has one read and one write port, and
// each moved or inspected element needs a read then a use.
// Reset clears the fill count and the controller; the memory holds no reset state.
// Each result sits on res for one cycle with res_valid high; the receiver cannot stall.
module array_table_insert_delete_search_top #(
    parameter int DEPTH = atids_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  atids_pkg::req_t req,
    output atids_pkg::res_t res,
    output logic            res_valid
);
    import atids_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    atids_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    atids_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res),
        .res_valid (res_valid)
    );

endmodule

FILE: bench/table_request_checker.sv
// Checker for the table block: predicts the results of every defined request and compares each result transfer.
module table_request_checker #(
    parameter int DEPTH = atids_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  atids_pkg::req_t req,
    input  atids_pkg::res_t res,
    input  logic            res_valid,
    output int              mismatches,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import atids_pkg::*;

    logic signed [31:0] cells [DEPTH];
    int fill = 0;
    res_t table_answers [$];

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    function automatic void report(input string what, input res_t want, input res_t got);
        if (mismatches < 10)
        begin
            $display("%0t: %s: expected value %0d pos %0d status %0d last %0b,",
                     $time, what, want.value_out, want.position_out, want.status,
                     want.last);
            $display("    got value %0d pos %0d status %0d last %0b",
                     got.value_out, got.position_out, got.status, got.last);
        end
        mismatches++;
    endfunction

    function automatic void compare_answer(input res_t want, input res_t got);
        string bad;
        bad = "";
        if (got.value_out !== want.value_out)
            bad = {bad, " value_out"};
        if (got.position_out !== want.position_out)
            bad = {bad, " position_out"};
        if (got.status !== want.status)
            bad = {bad, " status"};
        if (got.last !== want.last)
            bad = {bad, " last"};
        if (bad != "")
            report({"result mismatch in", bad}, want, got);
    endfunction

    function automatic void predict_request(input req_t r);
        res_t a;
        int p;
        int i;
        bit hit;
        a = '0;
        a.last = 1'b1;
        p = r.position;
        hit = 1'b0;
        case (r.req_type)
            REQ_CLEAR:
                fill = 0;
            REQ_APPEND:
                if (fill >= DEPTH)
                    a.status = ST_FULL;
                else
                begin
                    cells[fill] = r.value;
                    fill++;
                end
            REQ_DISPLAY:
                if (fill == 0)
                    a.status = ST_EMPTY;
                else
                begin
                    a.last = 1'b0;
                    for (i = 0; i < fill - 1; i++)
                    begin
                        a.value_out = cells[i];
                        a.position_out = 7'(i + 1);
                        table_answers.push_back(a);
                    end
                    a.value_out = cells[fill - 1];
                    a.position_out = 7'(fill);
                    a.last = 1'b1;
                end
            REQ_INSERT:
                if (fill >= DEPTH)
                    a.status = ST_FULL;
                else if (p < 1 || p > fill + 1)
                    a.status = ST_BAD_POS;
                else
                begin
                    for (i = fill; i >= p; i--)
                        cells[i] = cells[i - 1];
                    cells[p - 1] = r.value;
                    fill++;
                end
            REQ_DELETE:
                if (fill == 0)
                    a.status = ST_EMPTY;
                else if (p < 1 || p > fill)
                    a.status = ST_BAD_POS;
                else
                begin
                    for (i = p - 1; i < fill - 1; i++)
                        cells[i] = cells[i + 1];
                    fill--;
                end
            REQ_SEARCH:
            begin
                a.status = ST_NOT_FOUND;
                for (i = 0; i < fill && !hit; i++)
                begin
                    if (cells[i] == r.value)
                    begin
                        hit = 1'b1;
                        a.status = ST_OK;
                        a.position_out = 7'(i + 1);
                    end
                end
            end
            default:
                return;
        endcase
        table_answers.push_back(a);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid)
            begin
                if (table_answers.size() == 0)
                    report("result transfer with nothing pending", '0, res);
                else
                    compare_answer(table_answers.pop_front(), res);
            end
            if (start && !busy)
                predict_request(req);
            outstanding = table_answers.size();
        end
    end

endmodule

FILE: bench/array_table_insert_delete_search_top_test.sv
// Testbench top: drives table requests into the block and gives the verdict from the checker.
module array_table_insert_delete_search_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import atids_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int ITEM_TARGET = 220;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    res_t res;
    logic res_valid;
    int mismatches;
    int outstanding;

    int stim_fill = 0;
    int issued = 0;
    int calm_left = 0;
    int idle_cycles = 0;
    bit filled = 1'b0;
    logic signed [31:0] seen_vals [$];

    array_table_insert_delete_search_top #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .res(res),
        .res_valid(res_valid)
    );

    table_request_checker #(
        .DEPTH(DEPTH)
    ) table_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .res(res),
        .res_valid(res_valid),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || res_valid)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int draw_gap();
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            calm_left = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic signed [31:0] recall_value();
        if (seen_vals.size() == 0)
            return $urandom();
        return seen_vals[$urandom_range(0, seen_vals.size() - 1)];
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return recall_value();
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [6:0] bad_pos(input int limit);
        if ($urandom_range(0, 2) == 0)
            return 7'd0;
        return 7'($urandom_range(limit + 1, 127));
    endfunction

    task automatic issue(input logic [2:0] op, input logic signed [31:0] val,
                         input logic [6:0] pos);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req <= '{req_type: op, value: val, position: pos};
        do @(posedge clk); while (busy);
        @(negedge clk);
        case (op)
            REQ_CLEAR:
                stim_fill = 0;
            REQ_APPEND:
                if (stim_fill < DEPTH)
                    stim_fill++;
            REQ_INSERT:
                if (stim_fill < DEPTH && pos >= 1 && pos <= stim_fill + 1)
                    stim_fill++;
            REQ_DELETE:
                if (stim_fill > 0 && pos >= 1 && pos <= stim_fill)
                    stim_fill--;
            default:
                ;
        endcase
        if (op == REQ_APPEND || op == REQ_INSERT)
        begin
            seen_vals.push_back(val);
            if (seen_vals.size() > 24)
                void'(seen_vals.pop_front());
        end
        if (op <= REQ_SEARCH)
            issued++;
    endtask

    task automatic grow_one();
        if ($urandom_range(0, 1) == 0)
            issue(REQ_APPEND, pick_value(), 7'($urandom()));
        else
            issue(REQ_INSERT, pick_value(), 7'($urandom_range(1, stim_fill + 1)));
    endtask

    task automatic mixed_one();
        case ($urandom_range(0, 9))
            0, 1: issue(REQ_INSERT, pick_value(), 7'($urandom_range(1, stim_fill + 1)));
            2, 3:
                if (stim_fill > 0)
                    issue(REQ_DELETE, $urandom(), 7'($urandom_range(1, stim_fill)));
                else
                    issue(REQ_DELETE, $urandom(), 7'($urandom()));
            4, 5: issue(REQ_SEARCH, recall_value(), 7'($urandom()));
            6: issue(REQ_SEARCH, $urandom(), 7'($urandom()));
            7: issue(REQ_APPEND, pick_value(), 7'($urandom()));
            8: issue(REQ_INSERT, pick_value(), bad_pos(stim_fill + 1));
            default: issue(REQ_DELETE, $urandom(), bad_pos(stim_fill));
        endcase
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        issue(REQ_SEARCH, 0, 0);
        issue(REQ_DISPLAY, 0, 0);
        issue(REQ_DELETE, 0, 1);
        issue(REQ_DELETE, 0, 0);
        issue(REQ_INSERT, 5, 0);
        issue(REQ_INSERT, 5, 2);
        issue(REQ_INSERT, 32'sh8000_0000, 1);
        issue(REQ_APPEND, 32'sh7fff_ffff, 127);
        issue(REQ_APPEND, 0, 0);
        issue(REQ_INSERT, -1, 4);
        issue(REQ_INSERT, 9, 127);
        issue(REQ_INSERT, 32'sh7fff_ffff, 2);
        issue(REQ_DISPLAY, -1, 127);
        issue(REQ_SEARCH, 32'sh7fff_ffff, 0);
        issue(REQ_SEARCH, -1, 0);
        issue(REQ_SEARCH, 12345, 0);
        issue(REQ_DELETE, 0, 0);
        issue(REQ_DELETE, 0, 6);
        issue(REQ_DELETE, 0, 5);
        issue(REQ_DELETE, 0, 1);
        issue(REQ_SPARE_A, -1, 127);
        issue(REQ_SPARE_B, 0, 0);
        issue(REQ_DISPLAY, 0, 0);
        issue(REQ_CLEAR, -1, 127);
        issue(REQ_DISPLAY, 0, 0);

        while (issued < ITEM_TARGET)
        begin
            if (!filled && issued > ITEM_TARGET / 3)
            begin
                while (stim_fill < DEPTH)
                    grow_one();
                issue(REQ_APPEND, pick_value(), 7'($urandom()));
                issue(REQ_INSERT, pick_value(), 1);
                issue(REQ_INSERT, pick_value(), 0);
                issue(REQ_DISPLAY, 0, 0);
                issue(REQ_SEARCH, recall_value(), 0);
                issue(REQ_DELETE, 0, 7'(DEPTH));
                issue(REQ_DELETE, 0, 1);
                filled = 1'b1;
            end
            case ($urandom_range(0, 15))
                0: issue(REQ_CLEAR, $urandom(), 7'($urandom()));
                1, 2, 3: repeat ($urandom_range(2, 10)) grow_one();
                4: issue(REQ_DISPLAY, $urandom(), 7'($urandom()));
                5: issue(3'($urandom_range(REQ_SPARE_A, REQ_SPARE_B)), $urandom(), 7'($urandom()));
                default: mixed_one();
            endcase
        end

        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
